>>> design/hbsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbsa_pkg;

  // Field widths fixed by the request and result formats
  localparam int KIND_W   = 1;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 13;
  localparam int COUNT_W  = 13;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   given_slot;
    logic [COUNT_W-1:0]  in_use_count;
  } result_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } state_t;

endpackage

`default_nettype wire

>>> design/hbsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/hierarchical_bitmap_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A word accepted in ST_IDLE has its result strobed in the next cycle, in ST_RESOLVE.
// A new request is taken only in ST_IDLE, so not before the last one has finished the
//   read-modify-write of its leaf word via the single-port-read leaf RAM; busy covers the write-back.
// Reset: synchronous; afterwards busy stays high for a clearing pass that zeroes every
//   word of the leaf RAM; capacity writes are taken throughout.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module hierarchical_bitmap_slot_allocator_unit #(
  parameter int MAX_SLOTS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbsa_pkg::CAP_W-1:0]  cfg_data,
  input  logic                        start,
  output logic                        busy,
  input  hbsa_pkg::req_t              req,
  output logic                        done,
  output hbsa_pkg::result_t           result
);

  import hbsa_pkg::*;

  // WORD_BITS is a power of two: slot = word * WORD_BITS + bit
  localparam int LEAF_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

  state_t state, state_next;

  logic [WIDX_W-1:0]     clr_ptr;
  logic [LEAF_WORDS-1:0] summary;
  logic [CNT_W-1:0]      used_count;
  logic [CNT_W-1:0]      count_next;
  logic [CAP_W-1:0]      capacity_limit;

  // Request held across the read cycle
  logic [KIND_W-1:0] op_kind;
  logic [WIDX_W-1:0] op_word;
  logic [BIT_W-1:0]  op_bit;
  logic              op_bad;

  logic              accept;
  logic              sum_any;
  logic [WIDX_W-1:0] sum_idx;
  logic [31:0]       slot_wide;
  logic              free_oob;
  logic [WIDX_W-1:0] rd_addr;

  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] free_bits;
  logic                 fb_any;
  logic [BIT_W-1:0]     fb_idx;
  logic [BIT_W-1:0]     sel_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] new_word;
  logic [31:0]          alloc_slot;
  logic [31:0]          cap_eff;
  logic                 alloc_ok;
  logic                 free_ok;
  logic                 op_ok;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  assign accept = start && (state == ST_IDLE);

  // Lowest leaf word that still has a free slot
  always_comb begin
    sum_any = 1'b0;
    sum_idx = '0;
    for (int i = LEAF_WORDS - 1; i >= 0; i--) begin
      if (summary[i]) begin
        sum_any = 1'b1;
        sum_idx = WIDX_W'(i);
      end
    end
  end

  // Request decode and leaf read address
  always_comb begin
    slot_wide = 32'(req.slot_index);
    free_oob  = slot_wide >= 32'(MAX_SLOTS);
    if (req.kind == KIND_ALLOC) begin
      rd_addr = sum_idx;
    end else begin
      rd_addr = WIDX_W'(slot_wide >> BIT_W);
    end
  end

  hbsa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(LEAF_WORDS)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Lowest free bit of the leaf word just read
  always_comb begin
    free_bits = ~rd_data;
    fb_any    = 1'b0;
    fb_idx    = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        fb_any = 1'b1;
        fb_idx = BIT_W'(i);
      end
    end
  end

  // Modify step: decide, build the write-back word and the new count
  always_comb begin
    alloc_slot = (32'(op_word) << BIT_W) | 32'(fb_idx);
    if (32'(capacity_limit) > 32'(MAX_SLOTS)) begin
      cap_eff = 32'(MAX_SLOTS);
    end else begin
      cap_eff = 32'(capacity_limit);
    end
    alloc_ok = !op_bad && fb_any && (alloc_slot < cap_eff);
    free_ok  = !op_bad && rd_data[op_bit];
    op_ok    = (op_kind == KIND_ALLOC) ? alloc_ok : free_ok;

    sel_bit  = (op_kind == KIND_ALLOC) ? fb_idx : op_bit;
    bit_mask = '0;
    bit_mask[sel_bit] = 1'b1;
    if (op_kind == KIND_ALLOC) begin
      new_word = rd_data | bit_mask;
    end else begin
      new_word = rd_data & ~bit_mask;
    end

    count_next = used_count;
    if (op_kind == KIND_ALLOC) begin
      if (alloc_ok) begin
        count_next = used_count + CNT_W'(1);
      end
    end else if (free_ok && (used_count != '0)) begin
      count_next = used_count - CNT_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_ptr == WIDX_W'(LEAF_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs and RAM write port
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = 1'b0;
    cfg_ready = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = op_word;
    ram_wdata = new_word;
    result.status       = STATUS_OK;
    result.given_slot   = '0;
    result.in_use_count = COUNT_W'(32'(count_next));
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
      end
      ST_RESOLVE: begin
        done   = 1'b1;
        ram_we = op_ok;
        if (!op_ok) begin
          result.status = (op_kind == KIND_ALLOC) ? STATUS_FULL : STATUS_BAD_FREE;
        end else if (op_kind == KIND_ALLOC) begin
          result.given_slot = SLOT_W'(alloc_slot);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, summary word, count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_ptr        <= '0;
      summary        <= '1;
      used_count     <= '0;
      capacity_limit <= CAP_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_ptr <= clr_ptr + WIDX_W'(1);
      end
      if (cfg_valid) begin
        capacity_limit <= cfg_data;
      end
      if ((state == ST_RESOLVE) && op_ok) begin
        used_count <= count_next;
        if (op_kind == KIND_ALLOC) begin
          if (new_word == '1) begin
            summary[op_word] <= 1'b0;
          end
        end else begin
          summary[op_word] <= 1'b1;
        end
      end
    end
  end

  // Request capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= req.kind;
      op_word <= rd_addr;
      op_bit  <= BIT_W'(slot_wide);
      op_bad  <= (req.kind == KIND_ALLOC) ? !sum_any : free_oob;
    end
  end

endmodule

`default_nettype wire

>>> design/hbsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsa_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input hbsa_pkg::result_t result
);

  import hbsa_pkg::*;

  // Every accepted word answers in the next cycle
  a_answer_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word got no result in the next cycle");

  // No result without a word accepted just before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted word");

  // One result per word, never back to back
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // Failed requests hand out no slot
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_OK)) |-> (result.given_slot == '0))
    else $error("failed request carries a slot");

endmodule

bind hierarchical_bitmap_slot_allocator_unit hbsa_checker u_hbsa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
